>>> design/fbsync_pkg.sv
// shared constants and types for the flux bit byte sync and field extractor
// no dependencies; imported by fbsync_core and the top level

package fbsync_pkg;

    localparam int TRACK_BYTES       = 6656;
    localparam int SECTORS_PER_TRACK = 16;

    localparam int TRACK_BITS_W   = 17;
    localparam int BITS_COUNT_W   = TRACK_BITS_W + 1;
    localparam int POS_W          = 13;
    localparam int COUNT_W        = 9;

    localparam logic [TRACK_BITS_W-1:0] TRACK_BITS_RESET = 17'd51200;

    localparam logic [23:0] ADDR_PROLOGUE = 24'hD5AA96;
    localparam logic [23:0] DATA_PROLOGUE = 24'hD5AAAD;
    localparam logic [7:0]  SYNC_BYTE_0   = 8'hD5;
    localparam logic [7:0]  SYNC_BYTE_1   = 8'hAA;
    localparam logic [7:0]  ADDR_MARK     = 8'h96;
    localparam logic [7:0]  DATA_MARK     = 8'hAD;

    localparam logic [COUNT_W-1:0] ADDR_CAPTURE = 9'd11;
    localparam logic [COUNT_W-1:0] DATA_CAPTURE = 9'd346;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;

    // results of one item, handed from the core to the output buffer
    typedef struct packed {
        logic [1:0]       cnt;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic [7:0]       byte2;
        logic [POS_W-1:0] pos;
        logic             done;
    } fbsync_res_t;

endpackage

>>> design/fbsync_core.sv
// track state and per-bit step logic: byte framing, prologue match, capture
// depends on fbsync_pkg

module fbsync_core
    import fbsync_pkg::*;
#(
    parameter int NUM_TRACK_BYTES = TRACK_BYTES,
    parameter int NUM_SECTORS     = SECTORS_PER_TRACK
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic                    bit_in,
    input  logic                    restart,
    input  logic [TRACK_BITS_W-1:0] track_bits,
    output fbsync_res_t             res
);

    localparam logic [POS_W-1:0]   TRACK_BYTES_P = POS_W'(NUM_TRACK_BYTES);
    localparam logic [COUNT_W-1:0] SECTORS_P     = COUNT_W'(NUM_SECTORS);

    logic [7:0]              shifter_reg,  shifter_next;
    logic [23:0]             history_reg,  history_next;
    logic [COUNT_W-1:0]      capture_reg,  capture_next;
    logic [COUNT_W-1:0]      addr_seen_reg, addr_seen_next;
    logic [COUNT_W-1:0]      data_seen_reg, data_seen_next;
    logic [POS_W-1:0]        emitted_reg,  emitted_next;
    logic [BITS_COUNT_W-1:0] bits_reg,     bits_next;
    logic                    finished_reg, finished_next;

    // state as seen by this bit, after an optional restart
    logic [7:0]              sh_e;
    logic [23:0]             hist_e;
    logic [COUNT_W-1:0]      cap_e, addr_e, data_e;
    logic [POS_W-1:0]        emit_e;
    logic [BITS_COUNT_W-1:0] bits_e;
    logic                    fin_e;

    logic [BITS_COUNT_W-1:0] bit_limit;
    logic                    stop_pre, skip, stop_post;
    logic [7:0]              sh_new;
    logic [23:0]             hist_new;
    logic                    framed, is_addr, is_data, is_capt;
    logic [POS_W-1:0]        room;
    logic [1:0]              n_pro, n_out;

    always_comb begin
        sh_e   = restart ? '0 : shifter_reg;
        hist_e = restart ? '0 : history_reg;
        cap_e  = restart ? '0 : capture_reg;
        addr_e = restart ? '0 : addr_seen_reg;
        data_e = restart ? '0 : data_seen_reg;
        emit_e = restart ? '0 : emitted_reg;
        bits_e = restart ? '0 : bits_reg;
        fin_e  = restart ? 1'b0 : finished_reg;
    end

    assign bit_limit = {track_bits, 1'b0};

    assign stop_pre = (emit_e >= TRACK_BYTES_P) || (bits_e >= bit_limit) ||
                      (cap_e == '0 && addr_e == SECTORS_P && data_e == SECTORS_P);
    assign skip = fin_e || stop_pre;

    assign sh_new   = {sh_e[6:0], bit_in};
    assign framed   = sh_new[7];
    assign hist_new = {hist_e[15:0], sh_new};
    assign is_addr  = framed && (cap_e == '0) && (hist_new == ADDR_PROLOGUE);
    assign is_data  = framed && (cap_e == '0) && (hist_new == DATA_PROLOGUE);
    assign is_capt  = framed && (cap_e != '0);

    // bytes past the end of the track buffer are dropped
    assign room  = TRACK_BYTES_P - emit_e;
    assign n_pro = (room >= POS_W'(3)) ? 2'd3 : room[1:0];

    always_comb begin
        if (is_addr || is_data) begin
            n_out = n_pro;
        end else if (is_capt) begin
            n_out = 2'd1;
        end else begin
            n_out = 2'd0;
        end
    end

    always_comb begin
        shifter_next   = framed ? 8'h00 : sh_new;
        history_next   = framed ? hist_new : hist_e;
        emitted_next   = emit_e + POS_W'(n_out);
        bits_next      = bits_e + BITS_COUNT_W'(1);
        addr_seen_next = addr_e;
        data_seen_next = data_e;
        capture_next   = cap_e;
        if (is_addr) begin
            capture_next = ADDR_CAPTURE;
            if (addr_e < COUNT_MAX) addr_seen_next = addr_e + COUNT_W'(1);
        end else if (is_data) begin
            capture_next = DATA_CAPTURE;
            if (data_e < COUNT_MAX) data_seen_next = data_e + COUNT_W'(1);
        end else if (is_capt) begin
            capture_next = cap_e - COUNT_W'(1);
        end
        stop_post = (emitted_next >= TRACK_BYTES_P) || (bits_next >= bit_limit) ||
                    (capture_next == '0 && addr_seen_next == SECTORS_P &&
                     data_seen_next == SECTORS_P);
        finished_next = stop_post;
        // a stopped track keeps its state and only latches the stop
        if (skip) begin
            shifter_next   = sh_e;
            history_next   = hist_e;
            capture_next   = cap_e;
            addr_seen_next = addr_e;
            data_seen_next = data_e;
            emitted_next   = emit_e;
            bits_next      = bits_e;
            finished_next  = 1'b1;
        end
    end

    always_comb begin
        res.cnt   = skip ? 2'd0 : n_out;
        res.pos   = emit_e;
        res.done  = stop_post;
        res.byte0 = is_capt ? sh_new : SYNC_BYTE_0;
        res.byte1 = SYNC_BYTE_1;
        res.byte2 = is_addr ? ADDR_MARK : DATA_MARK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shifter_reg   <= '0;
            history_reg   <= '0;
            capture_reg   <= '0;
            addr_seen_reg <= '0;
            data_seen_reg <= '0;
            emitted_reg   <= '0;
            bits_reg      <= '0;
            finished_reg  <= 1'b0;
        end else if (step_en) begin
            shifter_reg   <= shifter_next;
            history_reg   <= history_next;
            capture_reg   <= capture_next;
            addr_seen_reg <= addr_seen_next;
            data_seen_reg <= data_seen_next;
            emitted_reg   <= emitted_next;
            bits_reg      <= bits_next;
            finished_reg  <= finished_next;
        end
    end

endmodule

>>> design/flux_bit_byte_sync_field_extractor_unit.sv
// top level of the flux bit byte sync and field extractor
// depends on fbsync_pkg and fbsync_core
//
//  channel | dir | handshake              | payload
//  s_      | in  | s_tvalid / s_tready    | s_tdata: stream_bit, s_tuser: restart
//  m_      | out | m_tvalid / m_tready    | m_tdata: data_byte, byte_position;
//          |     |                        | m_tlast: last_in_run, m_tuser: track_done
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: track_bits
//
// each input item is folded into the track state in the cycle it is accepted;
// its results land in a three-entry output register that drains one result a cycle
// while m_tready is high; a new item is taken as the last pending result leaves, so
// a prologue item (up to three results) holds the input side while the register drains
// synchronous active-low aresetn clears all but payload; track_bits returns to 51200
// a stalled m_ side holds the input side while any result is pending

module flux_bit_byte_sync_field_extractor_unit
    import fbsync_pkg::*;
#(
    parameter int NUM_TRACK_BYTES = TRACK_BYTES,
    parameter int NUM_SECTORS     = SECTORS_PER_TRACK
)
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // [0] stream_bit, [7:1] zero
    input  logic                    s_tuser,   // [0] restart

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // [7:0] data_byte, [20:8] byte_position
    output logic                    m_tlast,   // last_in_run
    output logic                    m_tuser,   // [0] track_done

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [TRACK_BITS_W-1:0] cfg_data
);

    logic [TRACK_BITS_W-1:0] track_bits_reg;
    fbsync_res_t             res;
    logic                    in_fire, out_fire;

    // output register: pending results, oldest in byte0
    logic [1:0]       ob_cnt_reg;
    logic [7:0]       ob_b0_reg, ob_b1_reg, ob_b2_reg;
    logic [POS_W-1:0] ob_pos_reg;
    logic             ob_done_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_bits_reg <= TRACK_BITS_RESET;
        end else if (cfg_valid) begin
            track_bits_reg <= cfg_data;
        end
    end

    // take a new item when nothing is pending or while the last pending result leaves
    assign s_tready = (ob_cnt_reg == 2'd0) || (ob_cnt_reg == 2'd1 && m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = (ob_cnt_reg != 2'd0);
    assign out_fire = m_tvalid && m_tready;

    fbsync_core #(
        .NUM_TRACK_BYTES (NUM_TRACK_BYTES),
        .NUM_SECTORS     (NUM_SECTORS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (in_fire),
        .bit_in     (s_tdata[0]),
        .restart    (s_tuser),
        .track_bits (track_bits_reg),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_cnt_reg <= 2'd0;
        end else if (in_fire && res.cnt != 2'd0) begin
            ob_cnt_reg <= res.cnt;
        end else if (out_fire) begin
            ob_cnt_reg <= ob_cnt_reg - 2'd1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (in_fire && res.cnt != 2'd0) begin
            ob_b0_reg   <= res.byte0;
            ob_b1_reg   <= res.byte1;
            ob_b2_reg   <= res.byte2;
            ob_pos_reg  <= res.pos;
            ob_done_reg <= res.done;
        end else if (out_fire) begin
            ob_b0_reg  <= ob_b1_reg;
            ob_b1_reg  <= ob_b2_reg;
            ob_pos_reg <= ob_pos_reg + POS_W'(1);
        end
    end

    assign m_tdata = {3'b000, ob_pos_reg, ob_b0_reg};
    assign m_tlast = (ob_cnt_reg == 2'd1);
    assign m_tuser = ob_done_reg;

endmodule

>>> bench/flux_bit_byte_sync_field_extractor_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for flux_bit_byte_sync_field_extractor_unit: flux bits go in, and every
// emitted track byte is compared with a bit-accurate predictor kept alongside the stream
// depends on fbsync_pkg and the design sources only

module flux_bit_byte_sync_field_extractor_unit_test;
    import fbsync_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int IDLE_PERCENT   = 12;
    localparam int SQUEEZE_CYCLES = 300;
    // the hold-off starts while the first prologue still has bytes waiting
    localparam int SQUEEZE_AFTER  = 1;
    localparam int QUIET_FROM     = 360;
    localparam int QUIET_TO       = 560;
    localparam int MAX_REPORTED   = 10;
    localparam logic [7:0] SELF_SYNC = 8'hFF;

    typedef struct packed {
        logic restart;
        logic flux;
    } flux_item_t;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        logic             last;
        logic             done;
    } track_byte_t;

    logic                    aclk;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [23:0]             m_tdata;
    logic                    m_tlast;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [TRACK_BITS_W-1:0] cfg_data  = '0;

    flux_bit_byte_sync_field_extractor_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    flux_item_t  pending_bits[$];
    track_byte_t expected_bytes[$];
    track_byte_t staged_bytes[$];

    int items_queued    = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int cycle_count     = 0;
    int squeeze_left    = 0;
    bit squeeze_done    = 1'b0;

    // predictor copy of the track state
    logic [TRACK_BITS_W-1:0] track_bits_r   = TRACK_BITS_RESET;
    logic [7:0]              shifter_r      = '0;
    logic [23:0]             history_r      = '0;
    logic [COUNT_W-1:0]      capture_left_r = '0;
    logic [COUNT_W-1:0]      addr_fields_r  = '0;
    logic [COUNT_W-1:0]      data_fields_r  = '0;
    logic [POS_W-1:0]        emitted_r      = '0;
    logic [BITS_COUNT_W-1:0] bits_seen_r    = '0;
    logic                    finished_r     = 1'b0;

    wire quiet_stretch = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic stop_reached();
        return (emitted_r >= POS_W'(TRACK_BYTES)) ||
               (bits_seen_r >= {track_bits_r, 1'b0}) ||
               (capture_left_r == '0 && addr_fields_r == COUNT_W'(SECTORS_PER_TRACK) &&
                data_fields_r == COUNT_W'(SECTORS_PER_TRACK));
    endfunction

    // bytes past the end of the buffer are dropped silently
    function automatic void stage_byte(input logic [7:0] value);
        track_byte_t entry;
        if (emitted_r >= POS_W'(TRACK_BYTES))
            return;
        entry.data = value;
        entry.pos  = emitted_r;
        entry.last = 1'b0;
        entry.done = 1'b0;
        staged_bytes.push_back(entry);
        emitted_r++;
    endfunction

    function automatic void stage_prologue(input logic [7:0] mark);
        stage_byte(SYNC_BYTE_0);
        stage_byte(SYNC_BYTE_1);
        stage_byte(mark);
    endfunction

    // folds one accepted flux bit into the track state and queues the bytes it emits
    function automatic void fold_flux_bit(input logic flux, input logic restart);
        track_byte_t entry;
        int          k;
        staged_bytes.delete();
        if (restart) begin
            shifter_r      = '0;
            history_r      = '0;
            capture_left_r = '0;
            addr_fields_r  = '0;
            data_fields_r  = '0;
            emitted_r      = '0;
            bits_seen_r    = '0;
            finished_r     = 1'b0;
        end
        // track already over: the bit is swallowed
        if (finished_r || stop_reached()) begin
            finished_r = 1'b1;
            return;
        end
        shifter_r = {shifter_r[6:0], flux};
        if (shifter_r[7]) begin
            history_r = {history_r[15:0], shifter_r};
            if (capture_left_r == '0) begin
                if (history_r == ADDR_PROLOGUE) begin
                    if (addr_fields_r < COUNT_MAX)
                        addr_fields_r++;
                    stage_prologue(ADDR_MARK);
                    capture_left_r = ADDR_CAPTURE;
                end else if (history_r == DATA_PROLOGUE) begin
                    if (data_fields_r < COUNT_MAX)
                        data_fields_r++;
                    stage_prologue(DATA_MARK);
                    capture_left_r = DATA_CAPTURE;
                end
            end else begin
                stage_byte(shifter_r);
                capture_left_r--;
            end
            shifter_r = '0;
        end
        bits_seen_r++;
        if (stop_reached())
            finished_r = 1'b1;
        for (k = 0; k < staged_bytes.size(); k++) begin
            entry      = staged_bytes[k];
            entry.last = (k == staged_bytes.size() - 1);
            entry.done = finished_r;
            expected_bytes.push_back(entry);
        end
    endfunction

    // ---------------------------------------------------------------- flux bit driver

    always @(posedge aclk) begin : bit_driver
        flux_item_t next_item;
        logic       offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                fold_flux_bit(s_tdata[0], s_tuser);
                items_taken++;
            end
            // a new item is only put up once the previous one has gone
            if (!s_tvalid || s_tready) begin
                offer = (pending_bits.size() != 0) &&
                        (quiet_stretch || $urandom_range(0, 99) >= IDLE_PERCENT);
                if (offer) begin
                    next_item = pending_bits.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'b0, next_item.flux};
                    s_tuser   <= next_item.restart;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result side

    // one long hold-off once results are flowing, random gaps outside the quiet stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!squeeze_done && results_checked >= SQUEEZE_AFTER) begin
                squeeze_left = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            if (squeeze_left > 0) begin
                squeeze_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge aclk) begin : byte_monitor
        track_byte_t got;
        track_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.data = m_tdata[7:0];
            got.pos  = m_tdata[20:8];
            got.last = m_tlast;
            got.done = m_tuser;
            if (expected_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %h at position %0d last %b done %b",
                                        got.data, got.pos, got.last, got.done));
            end else begin
                want = expected_bytes.pop_front();
                if (got.data !== want.data || got.pos !== want.pos ||
                    got.last !== want.last || got.done !== want.done)
                    note_mismatch($sformatf(
                        "expected byte %h pos %0d last %b done %b, got %h pos %0d last %b done %b",
                        want.data, want.pos, want.last, want.done,
                        got.data, got.pos, got.last, got.done));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("flux_bit_byte_sync_field_extractor_unit_test: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stream building

    task automatic queue_bit(input logic flux, input logic restart);
        flux_item_t entry;
        entry.flux    = flux;
        entry.restart = restart;
        pending_bits.push_back(entry);
        items_queued++;
    endtask

    // msb first, as the drive delivers it
    task automatic queue_byte(input logic [7:0] value, input logic restart_first);
        int i;
        for (i = 7; i >= 0; i--)
            queue_bit(value[i], restart_first && i == 7);
    endtask

    task automatic queue_noise(input int count);
        repeat (count) queue_bit(1'($urandom_range(0, 1)), 1'b0);
    endtask

    // sync gap, prologue, then captured bytes with the top bit set and the odd stray zero
    task automatic queue_field(input logic [7:0] mark, input int capture_count);
        logic [7:0] payload;
        repeat ($urandom_range(0, 2)) begin
            queue_byte(SELF_SYNC, 1'b0);
            repeat ($urandom_range(0, 2)) queue_bit(1'b0, 1'b0);
        end
        queue_byte(SYNC_BYTE_0, 1'b0);
        queue_byte(SYNC_BYTE_1, 1'b0);
        queue_byte(mark, 1'b0);
        repeat (capture_count) begin
            if ($urandom_range(0, 7) == 0)
                queue_bit(1'b0, 1'b0);
            payload = 8'($urandom_range(128, 255));
            queue_byte(payload, 1'b0);
        end
    endtask

    // mostly well-formed address fields, with cut-off data fields, broken prologues and noise
    task automatic random_track(input int target, input logic with_restart);
        int         first;
        int         pick;
        logic [7:0] stray;
        first = items_queued;
        if (with_restart)
            queue_bit(1'($urandom_range(0, 1)), 1'b1);
        while (items_queued - first < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                queue_field(ADDR_MARK, int'(ADDR_CAPTURE));
            end else if (pick < 65) begin
                // data field abandoned part way by a new track
                queue_field(DATA_MARK, $urandom_range(3, 12));
                queue_bit(1'($urandom_range(0, 1)), 1'b1);
            end else if (pick < 80) begin
                queue_byte(SYNC_BYTE_0, 1'b0);
                queue_byte(SYNC_BYTE_1, 1'b0);
                stray = 8'($urandom_range(128, 255));
                queue_byte(stray, 1'b0);
            end else if (pick < 90) begin
                queue_noise($urandom_range(1, 16));
            end else begin
                stray = 8'($urandom_range(128, 255));
                queue_byte(stray, 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------- sequencing

    task automatic wait_until_idle();
        while (items_taken != items_queued || expected_bytes.size() != 0)
            @(posedge aclk);
        // a swallowed bit may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_track_bits(input logic [TRACK_BITS_W-1:0] bits_per_rev);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= bits_per_rev;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        track_bits_r = bits_per_rev;
    endtask

    initial begin : run_sequence
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: an address prologue straight after a restart, then a lone zero
        queue_byte(SYNC_BYTE_0, 1'b1);
        queue_byte(SYNC_BYTE_1, 1'b0);
        queue_byte(ADDR_MARK, 1'b0);
        queue_bit(1'b0, 1'b0);
        random_track(80, 1'b0);
        wait_until_idle();

        // longest track allowed
        write_track_bits({TRACK_BITS_W{1'b1}});
        random_track(60, 1'b1);
        queue_noise(24);
        wait_until_idle();

        // short track written over a longer one: the first bits find it already over
        write_track_bits(TRACK_BITS_W'($urandom_range(20, 50)));
        queue_noise(8);
        random_track(40, 1'b1);
        wait_until_idle();

        // one-bit track stops after two bits
        write_track_bits(TRACK_BITS_W'(1));
        random_track(8, 1'b1);
        wait_until_idle();

        if (mismatches == 0)
            $display("flux_bit_byte_sync_field_extractor_unit_test: PASS");
        else
            $display("flux_bit_byte_sync_field_extractor_unit_test: FAIL");
        $finish;
    end

endmodule
